// ===== design/diff_drive_odometry_rk2_unit_macros.svh =====
// assertion helpers shared by the odometry unit
`ifndef DIFF_DRIVE_ODOMETRY_RK2_UNIT_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_RK2_UNIT_MACROS_SVH

// same-cycle implication
`define DDO_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("odometry unit check failed");

// next-cycle implication
`define DDO_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("odometry unit check failed");

`endif

// ===== design/ddo_pkg.sv =====
package ddo_pkg;

   localparam int FracBits    = 16;
   localparam int CordicSteps = 16;
   localparam int MulCycles   = 32;
   localparam int DivW        = 56;
   localparam int DivCntW     = $clog2(DivW);

   localparam logic [33:0] RadToBam = 34'd683565276;
   localparam logic [33:0] CordicX0 = 34'd652032874;

   localparam logic [7:0] REG_RADIUS = 8'd0;
   localparam logic [7:0] REG_SEP    = 8'd1;

   localparam logic [15:0] RadiusReset = 16'd3277;
   localparam logic [19:0] SepReset    = 20'd19661;

   function automatic logic [31:0] sat32(input logic signed [65:0] v);
      logic [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -66'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [33:0] abs34(input logic signed [33:0] v);
      logic [33:0] r;
      r = v[33] ? 34'(-v) : 34'(v);
      return r;
   endfunction

   function automatic logic [33:0] atan_bam(input logic [4:0] i);
      logic [33:0] r;
      unique case (i)
         5'd0:  r = 34'd536870912;
         5'd1:  r = 34'd316933406;
         5'd2:  r = 34'd167458907;
         5'd3:  r = 34'd85004756;
         5'd4:  r = 34'd42667331;
         5'd5:  r = 34'd21354465;
         5'd6:  r = 34'd10679838;
         5'd7:  r = 34'd5340245;
         5'd8:  r = 34'd2670163;
         5'd9:  r = 34'd1335087;
         5'd10: r = 34'd667544;
         5'd11: r = 34'd333772;
         5'd12: r = 34'd166886;
         5'd13: r = 34'd83443;
         5'd14: r = 34'd41722;
         5'd15: r = 34'd20861;
         5'd16: r = 34'd10430;
         5'd17: r = 34'd5215;
         5'd18: r = 34'd2608;
         5'd19: r = 34'd1304;
         5'd20: r = 34'd652;
         5'd21: r = 34'd326;
         5'd22: r = 34'd163;
         5'd23: r = 34'd81;
         5'd24: r = 34'd41;
         5'd25: r = 34'd20;
         5'd26: r = 34'd10;
         5'd27: r = 34'd5;
         5'd28: r = 34'd3;
         5'd29: r = 34'd1;
         5'd30: r = 34'd1;
         default: r = 34'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== design/diff_drive_odometry_rk2_unit.sv =====
// channel   ports                                          direction
// req       req_valid/ready, left/right angle, timestamp   in
// rsp       rsp_valid/ready, pose, speeds, dt_zero         out
// csr       csr_valid/ready, csr_index, csr_data           in
//
// one word at a time through a shared shift-add multiplier,
// a restoring divider and an iterative cordic;
// two divides fewer when dt is zero
// synchronous reset clears pose, speeds and history and loads the radius and separation registers with their defaults
// a finished word waits in the output register; the next word is taken meanwhile
`include "diff_drive_odometry_rk2_unit_macros.svh"

module diff_drive_odometry_rk2_unit import ddo_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_left_angle,
   input  logic signed [31:0] req_right_angle,
   input  logic [31:0]        req_timestamp,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [31:0]        rsp_heading,
   output logic signed [31:0] rsp_lin_speed,
   output logic signed [31:0] rsp_ang_speed,
   output logic               rsp_dt_zero,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_MUL_L   = 5'd1;
   localparam logic [4:0] ST_MUL_R   = 5'd2;
   localparam logic [4:0] ST_DIV_TH  = 5'd3;
   localparam logic [4:0] ST_MUL_WDT = 5'd4;
   localparam logic [4:0] ST_MUL_VDT = 5'd5;
   localparam logic [4:0] ST_MUL_KTH = 5'd6;
   localparam logic [4:0] ST_MUL_KW  = 5'd7;
   localparam logic [4:0] ST_COR_NEW = 5'd8;
   localparam logic [4:0] ST_COR_OLD = 5'd9;
   localparam logic [4:0] ST_MUL_LC  = 5'd10;
   localparam logic [4:0] ST_MUL_VC  = 5'd11;
   localparam logic [4:0] ST_MUL_LS  = 5'd12;
   localparam logic [4:0] ST_MUL_VS  = 5'd13;
   localparam logic [4:0] ST_UPD     = 5'd14;
   localparam logic [4:0] ST_DIV_V   = 5'd15;
   localparam logic [4:0] ST_DIV_W   = 5'd16;
   localparam logic [4:0] ST_DONE    = 5'd17;

   logic [4:0]  state_ff, state_in;
   logic        run_ff, run_in;
   logic        mul_neg_ff, mul_neg_in;
   logic        div_neg_ff, div_neg_in;
   logic [15:0] radius_ff;
   logic [19:0] sep_ff;

   logic [31:0] prev_l_ff, prev_l_in, prev_r_ff, prev_r_in, prev_t_ff, prev_t_in;
   logic [31:0] x_ff, x_in, y_ff, y_in, theta_ff, theta_in, old_th_ff, old_th_in;
   logic [31:0] v_ff, v_in, w_ff, w_in;
   logic [32:0] dl_l_ff, dl_l_in, dl_r_ff, dl_r_in;
   logic [31:0] dt_ff, dt_in;
   logic [32:0] ll_ff, ll_in, lr_ff, lr_in;
   logic [31:0] lt_ff, lt_in, th_ff, th_in, wdt_ff, wdt_in, vdt_ff, vdt_in;
   logic [32:0] bth_ff, bth_in;
   logic [33:0] cn_ff, cn_in, sn_ff, sn_in, co_ff, co_in, so_ff, so_in;
   logic [34:0] tx_ff, tx_in, ty_ff, ty_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] o_x_ff, o_x_in, o_y_ff, o_y_in, o_th_ff, o_th_in;
   logic [31:0] o_v_ff, o_v_in, o_w_ff, o_w_in;
   logic        o_z_ff, o_z_in;

   logic                is_mul, is_div, is_cor, unit_done;
   logic                mul_start, div_start, cor_start;
   logic                mul_done, div_done, cor_done;
   logic signed [33:0]  op_a, op_b;
   logic [33:0]         a_abs, b_abs;
   logic [64:0]         mul_p;
   logic signed [65:0]  prod_s, prod_f, prod_16, prod_30;
   logic [DivW-1:0]     div_n, div_q;
   logic [31:0]         div_d;
   logic                div_neg;
   logic signed [56:0]  quo_s;
   logic [31:0]         quo_sat;
   logic [31:0]         cor_ang;
   logic signed [33:0]  cor_c, cor_s;
   logic signed [33:0]  dd;
   logic [33:0]         dd_mag, lt_mag, th_mag;
   logic [33:0]         lsum;
   logic [32:0]         bsum;
   logic signed [65:0]  xsum, ysum;
   logic                load_out;

   assign is_mul = (state_ff == ST_MUL_L) || (state_ff == ST_MUL_R) ||
                   (state_ff == ST_MUL_WDT) || (state_ff == ST_MUL_VDT) ||
                   (state_ff == ST_MUL_KTH) || (state_ff == ST_MUL_KW) ||
                   (state_ff == ST_MUL_LC) || (state_ff == ST_MUL_VC) ||
                   (state_ff == ST_MUL_LS) || (state_ff == ST_MUL_VS);
   assign is_div = (state_ff == ST_DIV_TH) || (state_ff == ST_DIV_V) ||
                   (state_ff == ST_DIV_W);
   assign is_cor = (state_ff == ST_COR_NEW) || (state_ff == ST_COR_OLD);

   assign mul_start = is_mul && !run_ff;
   assign div_start = is_div && !run_ff;
   assign cor_start = is_cor && !run_ff;
   assign unit_done = (is_mul && mul_done) || (is_div && div_done) || (is_cor && cor_done);
   assign run_in    = run_ff ? !unit_done : (is_mul || is_div || is_cor);

   assign a_abs      = abs34(op_a);
   assign b_abs      = abs34(op_b);
   assign mul_neg_in = mul_start ? (op_a[33] ^ op_b[33]) : mul_neg_ff;
   assign div_neg_in = div_start ? div_neg : div_neg_ff;

   assign prod_s  = mul_neg_ff ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});
   assign prod_f  = prod_s >>> FracBits;
   assign prod_16 = prod_s >>> 16;
   assign prod_30 = prod_s >>> 30;
   assign quo_s   = div_neg_ff ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
   assign quo_sat = sat32({{9{quo_s[56]}}, quo_s});

   assign dd     = $signed({ll_ff[32], ll_ff}) - $signed({lr_ff[32], lr_ff});
   assign dd_mag = abs34(dd);
   assign lt_mag = abs34($signed({{2{lt_ff[31]}}, lt_ff}));
   assign th_mag = abs34($signed({{2{th_ff[31]}}, th_ff}));
   assign lsum   = {ll_ff[32], ll_ff} + {lr_ff[32], lr_ff};
   assign bsum   = bth_ff + prod_f[32:0];
   assign xsum   = $signed({{34{x_ff[31]}}, x_ff}) + $signed({{32{tx_ff[34]}}, tx_ff[34:1]});
   assign ysum   = $signed({{34{y_ff[31]}}, y_ff}) + $signed({{32{ty_ff[34]}}, ty_ff[34:1]});
   assign load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   ddo_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (a_abs[32:0]),
      .b     (b_abs[31:0]),
      .done  (mul_done),
      .p     (mul_p)
   );

   ddo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .n     (div_n),
      .d     (div_d),
      .done  (div_done),
      .q     (div_q)
   );

   ddo_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_ang),
      .done    (cor_done),
      .cos_out (cor_c),
      .sin_out (cor_s)
   );

   always_comb begin
      state_in  = state_ff;
      prev_l_in = prev_l_ff;
      prev_r_in = prev_r_ff;
      prev_t_in = prev_t_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      theta_in  = theta_ff;
      old_th_in = old_th_ff;
      v_in      = v_ff;
      w_in      = w_ff;
      dl_l_in   = dl_l_ff;
      dl_r_in   = dl_r_ff;
      dt_in     = dt_ff;
      ll_in     = ll_ff;
      lr_in     = lr_ff;
      lt_in     = lt_ff;
      th_in     = th_ff;
      wdt_in    = wdt_ff;
      vdt_in    = vdt_ff;
      bth_in    = bth_ff;
      cn_in     = cn_ff;
      sn_in     = sn_ff;
      co_in     = co_ff;
      so_in     = so_ff;
      tx_in     = tx_ff;
      ty_in     = ty_ff;
      op_a      = '0;
      op_b      = '0;
      div_n     = '0;
      div_d     = 32'd1;
      div_neg   = 1'b0;
      cor_ang   = theta_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dl_l_in   = {req_left_angle[31], req_left_angle} - {prev_l_ff[31], prev_l_ff};
               dl_r_in   = {req_right_angle[31], req_right_angle} - {prev_r_ff[31], prev_r_ff};
               dt_in     = req_timestamp - prev_t_ff;
               prev_l_in = req_left_angle;
               prev_r_in = req_right_angle;
               prev_t_in = req_timestamp;
               state_in  = ST_MUL_L;
            end
         end
         ST_MUL_L: begin
            op_a = $signed({dl_l_ff[32], dl_l_ff});
            op_b = $signed({18'd0, radius_ff});
            if (mul_done) begin
               ll_in    = prod_16[32:0];
               state_in = ST_MUL_R;
            end
         end
         ST_MUL_R: begin
            op_a = $signed({dl_r_ff[32], dl_r_ff});
            op_b = $signed({18'd0, radius_ff});
            if (mul_done) begin
               lr_in    = prod_16[32:0];
               state_in = ST_DIV_TH;
            end
         end
         ST_DIV_TH: begin
            div_n   = DivW'({dd_mag, 16'd0});
            div_d   = {12'd0, (sep_ff == 20'd0) ? 20'd1 : sep_ff};
            div_neg = dd[33];
            if (div_done) begin
               th_in    = quo_sat;
               lt_in    = sat32($signed({{33{lsum[33]}}, lsum[33:1]}));
               state_in = ST_MUL_WDT;
            end
         end
         ST_MUL_WDT: begin
            op_a = $signed({{2{w_ff[31]}}, w_ff});
            op_b = $signed({2'd0, dt_ff});
            if (mul_done) begin
               wdt_in   = sat32(prod_f);
               state_in = ST_MUL_VDT;
            end
         end
         ST_MUL_VDT: begin
            op_a = $signed({{2{v_ff[31]}}, v_ff});
            op_b = $signed({2'd0, dt_ff});
            if (mul_done) begin
               vdt_in   = sat32(prod_f);
               state_in = ST_MUL_KTH;
            end
         end
         ST_MUL_KTH: begin
            op_a = $signed({{2{th_ff[31]}}, th_ff});
            op_b = $signed(RadToBam);
            if (mul_done) begin
               bth_in   = prod_f[32:0];
               state_in = ST_MUL_KW;
            end
         end
         ST_MUL_KW: begin
            op_a = $signed({{2{wdt_ff[31]}}, wdt_ff});
            op_b = $signed(RadToBam);
            if (mul_done) begin
               old_th_in = theta_ff;
               theta_in  = theta_ff + bsum[32:1];
               state_in  = ST_COR_NEW;
            end
         end
         ST_COR_NEW: begin
            cor_ang = theta_ff;
            if (cor_done) begin
               cn_in    = cor_c;
               sn_in    = cor_s;
               state_in = ST_COR_OLD;
            end
         end
         ST_COR_OLD: begin
            cor_ang = old_th_ff;
            if (cor_done) begin
               co_in    = cor_c;
               so_in    = cor_s;
               state_in = ST_MUL_LC;
            end
         end
         ST_MUL_LC: begin
            op_a = $signed({{2{lt_ff[31]}}, lt_ff});
            op_b = $signed(cn_ff);
            if (mul_done) begin
               tx_in    = prod_30[34:0];
               state_in = ST_MUL_VC;
            end
         end
         ST_MUL_VC: begin
            op_a = $signed({{2{vdt_ff[31]}}, vdt_ff});
            op_b = $signed(co_ff);
            if (mul_done) begin
               tx_in    = tx_ff + prod_30[34:0];
               state_in = ST_MUL_LS;
            end
         end
         ST_MUL_LS: begin
            op_a = $signed({{2{lt_ff[31]}}, lt_ff});
            op_b = $signed(sn_ff);
            if (mul_done) begin
               ty_in    = prod_30[34:0];
               state_in = ST_MUL_VS;
            end
         end
         ST_MUL_VS: begin
            op_a = $signed({{2{vdt_ff[31]}}, vdt_ff});
            op_b = $signed(so_ff);
            if (mul_done) begin
               ty_in    = ty_ff + prod_30[34:0];
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            x_in     = sat32(xsum);
            y_in     = sat32(ysum);
            state_in = (dt_ff == 32'd0) ? ST_DONE : ST_DIV_V;
         end
         ST_DIV_V: begin
            div_n   = DivW'({lt_mag[31:0], {FracBits{1'b0}}});
            div_d   = dt_ff;
            div_neg = lt_ff[31];
            if (div_done) begin
               v_in     = quo_sat;
               state_in = ST_DIV_W;
            end
         end
         ST_DIV_W: begin
            div_n   = DivW'({th_mag[31:0], {FracBits{1'b0}}});
            div_d   = dt_ff;
            div_neg = th_ff[31];
            if (div_done) begin
               w_in     = quo_sat;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_x_in  = o_x_ff;
      o_y_in  = o_y_ff;
      o_th_in = o_th_ff;
      o_v_in  = o_v_ff;
      o_w_in  = o_w_ff;
      o_z_in  = o_z_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         o_x_in  = x_ff;
         o_y_in  = y_ff;
         o_th_in = theta_ff;
         o_v_in  = v_ff;
         o_w_in  = w_ff;
         o_z_in  = (dt_ff == 32'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= RadiusReset;
         sep_ff       <= SepReset;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         prev_t_ff    <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         theta_ff     <= '0;
         v_ff         <= '0;
         w_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_index == REG_RADIUS) begin
            radius_ff <= csr_data[15:0];
         end
         if (csr_valid && csr_index == REG_SEP) begin
            sep_ff <= csr_data[19:0];
         end
         prev_l_ff <= prev_l_in;
         prev_r_ff <= prev_r_in;
         prev_t_ff <= prev_t_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         theta_ff  <= theta_in;
         v_ff      <= v_in;
         w_ff      <= w_in;
      end
      mul_neg_ff <= mul_neg_in;
      div_neg_ff <= div_neg_in;
      old_th_ff  <= old_th_in;
      dl_l_ff    <= dl_l_in;
      dl_r_ff    <= dl_r_in;
      dt_ff      <= dt_in;
      ll_ff      <= ll_in;
      lr_ff      <= lr_in;
      lt_ff      <= lt_in;
      th_ff      <= th_in;
      wdt_ff     <= wdt_in;
      vdt_ff     <= vdt_in;
      bth_ff     <= bth_in;
      cn_ff      <= cn_in;
      sn_ff      <= sn_in;
      co_ff      <= co_in;
      so_ff      <= so_in;
      tx_ff      <= tx_in;
      ty_ff      <= ty_in;
      o_x_ff     <= o_x_in;
      o_y_ff     <= o_y_in;
      o_th_ff    <= o_th_in;
      o_v_ff     <= o_v_in;
      o_w_ff     <= o_w_in;
      o_z_ff     <= o_z_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pos_x     = o_x_ff;
   assign rsp_pos_y     = o_y_ff;
   assign rsp_heading   = o_th_ff;
   assign rsp_lin_speed = o_v_ff;
   assign rsp_ang_speed = o_w_ff;
   assign rsp_dt_zero   = o_z_ff;

   `DDO_ASSERT_NXT(a_accept_starts, req_valid && req_ready, state_ff == ST_MUL_L)
   `DDO_ASSERT_NXT(a_done_waits, (state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready, state_ff == ST_DONE)
   `DDO_ASSERT_IMP(a_one_unit, 1'b1, $onehot0({mul_done, div_done, cor_done}))
   `DDO_ASSERT_IMP(a_mul_in_place, mul_done, is_mul)

endmodule

// ===== design/ddo_mul.sv =====
module ddo_mul import ddo_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] a,
   input  logic [31:0] b,
   output logic        done,
   output logic [64:0] p
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [32:0] a_ff, a_in;
   logic [65:0] p_ff, p_in;
   logic [33:0] sum;

   assign sum = p_ff[65:32] + (p_ff[0] ? {1'b0, a_ff} : 34'd0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      p_in    = p_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a;
         p_in    = {34'd0, b};
      end else if (busy_ff) begin
         p_in   = {1'b0, sum, p_ff[31:1]};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(MulCycles - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in;
      p_ff <= p_in;
   end

   assign done = done_ff;
   assign p    = p_ff[64:0];

endmodule

// ===== design/ddo_div.sv =====
module ddo_div import ddo_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [DivW-1:0] n,
   input  logic [31:0]     d,
   output logic            done,
   output logic [DivW-1:0] q
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic [31:0]        d_ff, d_in;
   logic [31:0]        r_ff, r_in;
   logic [DivW-1:0]    q_ff, q_in;
   logic [32:0]        trial;
   logic [33:0]        diff;

   assign trial = {r_ff, q_ff[DivW-1]};
   assign diff  = {1'b0, trial} - {2'b0, d_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         d_in    = d;
         r_in    = '0;
         q_in    = n;
      end else if (busy_ff) begin
         if (!diff[33]) begin
            r_in = diff[31:0];
            q_in = {q_ff[DivW-2:0], 1'b1};
         end else begin
            r_in = trial[31:0];
            q_in = {q_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DivCntW'(DivW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      d_ff <= d_in;
      r_ff <= r_in;
      q_ff <= q_in;
   end

   assign done = done_ff;
   assign q    = q_ff;

endmodule

// ===== design/ddo_cordic.sv =====
module ddo_cordic import ddo_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        angle,
   output logic               done,
   output logic signed [33:0] cos_out,
   output logic signed [33:0] sin_out
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [4:0]         it_ff, it_in;
   logic               flip_ff, flip_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [33:0] dx, dy, at;
   logic [31:0]        turned, ang2;

   assign dx     = y_ff >>> it_ff;
   assign dy     = x_ff >>> it_ff;
   assign at     = $signed(atan_bam(it_ff));
   assign turned = angle + 32'h4000_0000;
   assign ang2   = turned[31] ? angle + 32'h8000_0000 : angle;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      it_in   = it_ff;
      flip_in = flip_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         it_in   = '0;
         flip_in = turned[31];
         x_in    = $signed(CordicX0);
         y_in    = '0;
         z_in    = $signed({{2{ang2[31]}}, ang2});
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         it_in = it_ff + 5'd1;
         if (it_ff == 5'(CordicSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         it_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         it_ff   <= it_in;
      end
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

// ===== tb/tb.sv =====
module tb;
   import ddo_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 20000;
   localparam int LongHold  = 4000;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] hd;
      logic [31:0] v;
      logic [31:0] w;
      logic        dz;
   } pose_type;

   class odometry_scoreboard;
      logic [15:0] radius = RadiusReset;
      logic [19:0] sep = SepReset;
      logic [31:0] prev_l = '0, prev_r = '0, prev_t = '0;
      logic [31:0] x = '0, y = '0, theta = '0, v_reg = '0, w_reg = '0;
      pose_type expected_poses[$];
      int errors;
      longint atan_tab[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                               21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                               333772, 166886, 83443, 41722, 20861};

      function longint clip(longint a);
         if (a > 64'sd2147483647) return 64'sd2147483647;
         if (a < -64'sd2147483648) return -64'sd2147483648;
         return a;
      endfunction

      function longint scale_by_dt(longint a, longint unsigned b);
         longint unsigned mag, m;
         mag = (a < 0) ? longint'(-a) : longint'(a);
         m = mag * b;
         if (m == 0) return 0;
         if (a >= 0) return clip(longint'(m >> FracBits));
         return clip(-longint'((m - 1) >> FracBits) - 1);
      endfunction

      function longint to_bam(longint r);
         return (r * 64'sd683565276) >>> FracBits;
      endfunction

      function void rotate(logic [31:0] ang, output longint c, output longint s);
         longint cx, cy, z, dx, dy;
         logic [31:0] probe;
         bit flip;
         cx = 64'sd652032874;
         cy = 0;
         flip = 0;
         probe = ang + 32'h4000_0000;
         if (probe[31]) begin
            ang = ang + 32'h8000_0000;
            flip = 1;
         end
         z = longint'($signed(ang));
         for (int i = 0; i < CordicSteps; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
               cx -= dx; cy += dy; z -= atan_tab[i];
            end else begin
               cx += dx; cy -= dy; z += atan_tab[i];
            end
         end
         if (flip) begin
            cx = -cx; cy = -cy;
         end
         c = cx;
         s = cy;
      endfunction

      function void write_reg(logic [7:0] idx, logic [31:0] data);
         if (idx == REG_RADIUS) radius = data[15:0];
         else if (idx == REG_SEP) sep = data[19:0];
      endfunction

      function void note_input(logic [31:0] l_in, logic [31:0] r_in, logic [31:0] t_in);
         longint ll, lr, lt, th, v, w, wdt, vdt, dth, cn, sn, co, so, tx, ty, sp;
         longint unsigned dt;
         logic [31:0] dt32, old_th;
         pose_type e;
         dt32 = t_in - prev_t;
         dt = dt32;
         sp = (sep == 0) ? 1 : longint'(sep);
         ll = ((longint'($signed(l_in)) - longint'($signed(prev_l))) * longint'(radius)) >>> 16;
         lr = ((longint'($signed(r_in)) - longint'($signed(prev_r))) * longint'(radius)) >>> 16;
         lt = clip((ll + lr) >>> 1);
         th = clip(((ll - lr) * 65536) / sp);
         v = longint'($signed(v_reg));
         w = longint'($signed(w_reg));
         wdt = scale_by_dt(w, dt);
         vdt = scale_by_dt(v, dt);
         dth = (to_bam(th) + to_bam(wdt)) >>> 1;
         old_th = theta;
         theta = old_th + dth[31:0];
         rotate(theta, cn, sn);
         rotate(old_th, co, so);
         tx = ((lt * cn) >>> 30) + ((vdt * co) >>> 30);
         ty = ((lt * sn) >>> 30) + ((vdt * so) >>> 30);
         x = clip(longint'($signed(x)) + (tx >>> 1));
         y = clip(longint'($signed(y)) + (ty >>> 1));
         if (dt != 0) begin
            v_reg = clip((lt * 65536) / longint'(dt));
            w_reg = clip((th * 65536) / longint'(dt));
         end
         prev_l = l_in;
         prev_r = r_in;
         prev_t = t_in;
         e.x = x; e.y = y; e.hd = theta; e.v = v_reg; e.w = w_reg; e.dz = (dt == 0);
         expected_poses.push_back(e);
      endfunction

      function void check_result(pose_type got);
         pose_type e;
         if (expected_poses.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %p", got);
            return;
         end
         e = expected_poses.pop_front();
         if (got !== e) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch x %h/%h y %h/%h hd %h/%h", e.x, got.x, e.y, got.y,
                        e.hd, got.hd);
               $display("   v %h/%h w %h/%h dz %b/%b", e.v, got.v, e.w, got.w, e.dz, got.dz);
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [31:0] req_left_angle = 0;
   logic signed [31:0] req_right_angle = 0;
   logic [31:0] req_timestamp = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_lin_speed, rsp_ang_speed;
   logic [31:0] rsp_heading;
   logic rsp_dt_zero;
   logic csr_valid = 0;
   logic csr_ready;
   logic [7:0] csr_index = 0;
   logic [31:0] csr_data = 0;

   odometry_scoreboard sb = new();
   bit quiet = 0;
   bit hold_request = 0;
   int idle_cycles = 0;
   logic [31:0] cur_l = 0, cur_r = 0, cur_t = 0;

   diff_drive_odometry_rk2_unit dut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (req_valid && req_ready) begin
            sb.note_input(req_left_angle, req_right_angle, req_timestamp);
            idle_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result('{rsp_pos_x, rsp_pos_y, rsp_heading, rsp_lin_speed,
                              rsp_ang_speed, rsp_dt_zero});
            idle_cycles = 0;
         end
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_data);
            idle_cycles = 0;
         end
         if (idle_cycles >= IdleLimit) begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // receiver side
   initial begin
      @(negedge reset);
      forever begin
         if (hold_request) begin
            rsp_ready <= 0;
            repeat (LongHold) @(posedge clock);
            hold_request = 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   task automatic send_word(logic [31:0] l, logic [31:0] r, logic [31:0] t);
      req_valid <= 1;
      req_left_angle <= l;
      req_right_angle <= r;
      req_timestamp <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.expected_poses.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [7:0] idx, logic [31:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_motion(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 6) == 0) begin
            cur_l = $urandom;
            cur_r = $urandom;
            cur_t = $urandom;
         end else begin
            cur_l = cur_l + $urandom_range(0, 40000) - 20000;
            cur_r = cur_r + $urandom_range(0, 40000) - 20000;
            if ($urandom_range(0, 15) != 0) cur_t = cur_t + $urandom_range(1, 8000);
         end
         send_word(cur_l, cur_r, cur_t);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_word(0, 0, 0);
      send_word(32'd65536, 32'd65536, 32'd65536);
      send_word(32'd131072, 32'd65536, 32'd131072);
      send_word(32'h7fff_ffff, 32'h8000_0000, 32'd196608);
      send_word(32'h8000_0000, 32'h7fff_ffff, 32'd196609);
      send_word(32'h8000_0000, 32'h7fff_ffff, 32'd196609);
      send_word(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
      send_word(32'h0, 32'h8000_0000, 32'h0000_0010);
      send_word(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_0000);
      send_word(32'h7fff_ffff, 32'h0, 32'h7fff_0001);
      send_word(32'h7fff_ffff, 32'h0, 32'hffff_ffff);
      send_word(32'h0, 32'h0, 32'h0);
      drain();

      write_csr(REG_RADIUS, 32'hffff_ffff);
      write_csr(REG_SEP, 32'hfff0_0001);
      for (int i = 0; i < 12; i++) begin
         send_word(i[0] ? 32'h7fff_ffff : 32'h8000_0000, i[0] ? 32'h8000_0000 : 32'h7fff_ffff,
                   32'd100 * i + 32'd1);
      end
      for (int i = 0; i < 12; i++) begin
         send_word(i[0] ? 32'h7fff_ffff : 32'h8000_0000, i[0] ? 32'h7fff_ffff : 32'h8000_0000,
                   32'd5000 + 32'd3 * i);
      end
      send_motion(80);
      drain();

      write_csr(REG_RADIUS, 32'd1);
      write_csr(REG_SEP, 32'h000f_ffff);
      send_motion(80);
      drain();

      write_csr(REG_RADIUS, 32'd0);
      write_csr(REG_SEP, 32'd0);
      send_motion(30);
      drain();

      write_csr(8'd2, 32'd12345);
      write_csr(8'hff, 32'hffff_ffff);
      send_motion(20);
      drain();

      write_csr(REG_RADIUS, RadiusReset);
      write_csr(REG_SEP, SepReset);
      hold_request = 1;
      send_motion(20);
      drain();

      for (int k = 0; k < 6; k++) begin
         write_csr(REG_RADIUS, $urandom);
         write_csr(REG_SEP, $urandom);
         send_motion(90);
         drain();
      end

      quiet = 1;
      send_motion(140);
      drain();

      if (sb.errors == 0 && sb.expected_poses.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+design
design/ddo_pkg.sv
design/ddo_mul.sv
design/ddo_div.sv
design/ddo_cordic.sv
design/diff_drive_odometry_rk2_unit.sv
tb/tb.sv
